FILE: rtl/core/jacobi_poisson_stencil_assert.svh
// ----------------------------------------------------------------------------
// Jacobi stencil assertion macros
// Concurrent check macros of the stencil RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef JACOBI_POISSON_STENCIL_ASSERT_SVH
`define JACOBI_POISSON_STENCIL_ASSERT_SVH
`ifndef SYNTHESIS
`define JPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stencil check failed: same-cycle implication");
`define JPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stencil check failed: next-cycle implication");
`else
`define JPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define JPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/jps_pkg.sv
// ----------------------------------------------------------------------------
// Jacobi stencil package
// Shared types and constants of the streaming five-point Jacobi update.
// ----------------------------------------------------------------------------
package jps_pkg;

  // Width of the count registers and of the row and column result fields.
  localparam int CNT_W = 11;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_H_SQUARED = 2'd2;

  // Configuration reset values.
  localparam logic [CNT_W-1:0] COL_COUNT_RST = 11'd32;
  localparam logic [CNT_W-1:0] ROW_COUNT_RST = 11'd32;
  localparam logic [31:0]      H_SQUARED_RST = 32'd3943954;

  // Queue between the line buffer front and the arithmetic back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_LVL_W = 3;

  // Position of an updated point, carried alongside its operands.
  typedef struct packed {
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    logic             last;
  } pt_tag_t;

endpackage

FILE: rtl/core/jacobi_poisson_stencil.sv
// ----------------------------------------------------------------------------
// Jacobi five-point stencil
// Streaming Jacobi update for the Poisson equation with line buffers.
// ----------------------------------------------------------------------------
// The slab, interior plus a one-point border, enters in raster order on the
// input queue port: a transaction takes place when push is high and full low.
// in_grid_start marks the first point of a slab. Each point of row r gives
// the update of interior point (r-1, c) when c is an interior column.
// Results leave on the output queue port: the oldest result is shown while
// empty is low and taken when pop is high.
// While full is low, one point is taken per cycle. A result passes the line
// buffer reads, the operand queue entry and the product and neighbour sum
// in turn; the quarter and saturation are registered into the result.
// When pop stays low, the result register, the arithmetic stage and the four
// operand queue entries fill, then full rises until the receiver resumes.
// Reset clears the position counters, the queue and the pipeline and loads
// the default counts of 32 by 32 and the default h squared. The row buffers
// are not cleared; the first two rows of a slab fill them.
// Configuration writes are taken at once (cfg_ready is always high). The user
// must make them while no transaction is in flight; it is not enforced.
// ----------------------------------------------------------------------------
`include "jacobi_poisson_stencil_assert.svh"

module jacobi_poisson_stencil #(
  parameter int MAX_COLS   = 1024,
  parameter int MAX_ROWS   = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [31:0]                   in_u_value,
  input  logic [31:0]                   in_rhs_value,
  input  logic                          in_grid_start,
  output logic                          empty,
  input  logic                          pop,
  output logic [31:0]                   out_new_value,
  output logic [jps_pkg::CNT_W-1:0]     out_row,
  output logic [jps_pkg::CNT_W-1:0]     out_col,
  output logic                          out_last_point,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [jps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  localparam int VB = (VALUE_BITS > 32) ? 32 : ((VALUE_BITS < 16) ? 16 : VALUE_BITS);
  localparam int QW = 5 * VB + $bits(jps_pkg::pt_tag_t);

  logic [jps_pkg::CNT_W-1:0] col_count_r, row_count_r;
  logic [31:0]               h_squared_r;

  logic                        in_accept;
  logic                        front_push;
  logic [VB-1:0]               f_up, f_down, f_left, f_right, f_rhs;
  jps_pkg::pt_tag_t            f_tag;
  logic [QW-1:0]               q_head;
  logic                        q_not_empty, q_pop;
  logic [jps_pkg::Q_LVL_W-1:0] q_level;
  logic [VB-1:0]               b_up, b_down, b_left, b_right, b_rhs;
  jps_pkg::pt_tag_t            b_tag, res_tag;
  logic                        res_valid;
  logic [VB-1:0]               res_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= jps_pkg::COL_COUNT_RST;
      row_count_r <= jps_pkg::ROW_COUNT_RST;
      h_squared_r <= jps_pkg::H_SQUARED_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        jps_pkg::REG_COL_COUNT: col_count_r <= cfg_data[jps_pkg::CNT_W-1:0];
        jps_pkg::REG_ROW_COUNT: row_count_r <= cfg_data[jps_pkg::CNT_W-1:0];
        jps_pkg::REG_H_SQUARED: h_squared_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The queue must hold whatever the front stage is about to hand over.
  assign full = (q_level == jps_pkg::Q_LVL_W'(jps_pkg::Q_DEPTH)) ||
                ((q_level == jps_pkg::Q_LVL_W'(jps_pkg::Q_DEPTH - 1)) && front_push);
  assign in_accept = push && !full;

  jps_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .VALUE_W  (VB)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .u_value     (in_u_value[VB-1:0]),
    .rhs_value   (in_rhs_value[VB-1:0]),
    .grid_start  (in_grid_start),
    .col_count   (col_count_r),
    .row_count   (row_count_r),
    .push        (front_push),
    .up_value    (f_up),
    .down_value  (f_down),
    .left_value  (f_left),
    .right_value (f_right),
    .rhs_out     (f_rhs),
    .tag         (f_tag)
  );

  jps_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .push_data ({f_up, f_down, f_left, f_right, f_rhs, f_tag}),
    .pop       (q_pop),
    .pop_data  (q_head),
    .not_empty (q_not_empty),
    .level     (q_level)
  );

  assign {b_up, b_down, b_left, b_right, b_rhs, b_tag} = q_head;

  jps_back #(
    .VALUE_W (VB)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (q_not_empty),
    .in_pop      (q_pop),
    .up_value    (b_up),
    .down_value  (b_down),
    .left_value  (b_left),
    .right_value (b_right),
    .rhs_value   (b_rhs),
    .in_tag      (b_tag),
    .h_squared   (h_squared_r),
    .out_valid   (res_valid),
    .out_pop     (pop),
    .out_value   (res_value),
    .out_tag     (res_tag)
  );

  assign empty          = !res_valid;
  assign out_new_value  = 32'(res_value);
  assign out_row        = res_tag.row;
  assign out_col        = res_tag.col;
  assign out_last_point = res_tag.last;

  `JPS_ASSERT_IMPLY(a_queue_no_overflow, clk, rst_n, (q_level == jps_pkg::Q_LVL_W'(jps_pkg::Q_DEPTH)), !front_push)
  `JPS_ASSERT_IMPLY(a_queue_no_underflow, clk, rst_n, q_pop, q_not_empty)
  `JPS_ASSERT_IMPLY(a_result_not_overwritten, clk, rst_n, q_pop, (empty || pop))
  `JPS_ASSERT_NEXT(a_push_lands_in_queue, clk, rst_n, front_push, q_not_empty)

endmodule

FILE: rtl/core/jps_front.sv
// ----------------------------------------------------------------------------
// Jacobi stencil front end
// Tracks the raster position, keeps the row buffers and gathers the five
// operands of each interior update.
// ----------------------------------------------------------------------------
module jps_front #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024,
  parameter int VALUE_W  = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic [VALUE_W-1:0]        u_value,
  input  logic [VALUE_W-1:0]        rhs_value,
  input  logic                      grid_start,
  input  logic [jps_pkg::CNT_W-1:0] col_count,
  input  logic [jps_pkg::CNT_W-1:0] row_count,
  output logic                      push,
  output logic [VALUE_W-1:0]        up_value,
  output logic [VALUE_W-1:0]        down_value,
  output logic [VALUE_W-1:0]        left_value,
  output logic [VALUE_W-1:0]        right_value,
  output logic [VALUE_W-1:0]        rhs_out,
  output jps_pkg::pt_tag_t          tag
);

  localparam int DEPTH = MAX_COLS + 2;
  localparam int CW    = $clog2(MAX_COLS + 2);
  localparam int RW    = $clog2(MAX_ROWS + 3);
  localparam int CX    = CW + 1;
  localparam int RX    = RW + 1;

  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;

  logic [CX-1:0] cols, c0, c1, c2;
  logic [RX-1:0] rows, r0, r1, r2;
  logic          ignore, compute, last;
  logic [CW-1:0] addr_c, addr_right;

  logic [VALUE_W-1:0] above_mem [DEPTH];
  logic [VALUE_W-1:0] mid_mem   [DEPTH];
  logic [VALUE_W-1:0] rhs_mem   [DEPTH];

  logic [VALUE_W-1:0] up_rd_r, mid_rd_r, right_rd_r, rhs_rd_r, down_r, left_r;
  logic [CW-1:0]      s1_addr_r;
  logic               s1_valid_r, s1_compute_r;
  jps_pkg::pt_tag_t   s1_tag_r;

  // Counts of zero act as one, counts above the buffer size as the maximum.
  always_comb begin
    if (col_count == '0) begin
      cols = CX'(1);
    end else if (32'(col_count) > 32'(MAX_COLS)) begin
      cols = CX'(MAX_COLS);
    end else begin
      cols = CX'(col_count);
    end
    if (row_count == '0) begin
      rows = RX'(1);
    end else if (32'(row_count) > 32'(MAX_ROWS)) begin
      rows = RX'(MAX_ROWS);
    end else begin
      rows = RX'(row_count);
    end
  end

  always_comb begin
    c0 = grid_start ? '0 : CX'(col_r);
    r0 = grid_start ? '0 : RX'(row_r);
    // A column beyond a shortened row wraps to the start of the next row.
    if (c0 > cols + CX'(1)) begin
      c1 = '0;
      r1 = r0 + RX'(1);
    end else begin
      c1 = c0;
      r1 = r0;
    end
    ignore  = r1 > rows + RX'(1);
    compute = !ignore && (r1 >= RX'(2)) && (c1 != '0) && (c1 <= cols);
    last    = (r1 - RX'(1) == rows) && (c1 == cols);
    c2 = c1 + CX'(1);
    r2 = r1;
    if (c2 > cols + CX'(1)) begin
      c2 = '0;
      r2 = r1 + RX'(1);
    end
  end

  assign addr_c     = c1[CW-1:0];
  assign addr_right = CW'(c1 + CX'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (accept) begin
      if (ignore) begin
        row_r <= RW'(rows + RX'(2));
        col_r <= '0;
      end else begin
        row_r <= RW'(r2);
        col_r <= CW'(c2);
      end
    end
  end

  // Reads see the contents from before this transaction's own writes.
  always_ff @(posedge clk) begin
    if (accept && !ignore) begin
      mid_mem[addr_c] <= u_value;
      rhs_mem[addr_c] <= rhs_value;
      up_rd_r         <= above_mem[addr_c];
      mid_rd_r        <= mid_mem[addr_c];
      right_rd_r      <= mid_mem[addr_right];
      rhs_rd_r        <= rhs_mem[addr_c];
      down_r          <= u_value;
      s1_addr_r       <= addr_c;
      s1_tag_r.row    <= jps_pkg::CNT_W'(r1 - RX'(1));
      s1_tag_r.col    <= jps_pkg::CNT_W'(c1);
      s1_tag_r.last   <= last;
    end
  end

  // The middle row value moves up once it has been read. It is also the
  // left neighbour of the next point in the same row.
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      above_mem[s1_addr_r] <= mid_rd_r;
      left_r               <= mid_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s1_compute_r <= 1'b0;
    end else begin
      s1_valid_r   <= accept && !ignore;
      s1_compute_r <= accept && compute;
    end
  end

  assign push        = s1_valid_r && s1_compute_r;
  assign up_value    = up_rd_r;
  assign down_value  = down_r;
  assign left_value  = left_r;
  assign right_value = right_rd_r;
  assign rhs_out     = rhs_rd_r;
  assign tag         = s1_tag_r;

endmodule

FILE: rtl/core/jps_queue.sv
// ----------------------------------------------------------------------------
// Jacobi stencil operand queue
// Short register queue that decouples the front end from the arithmetic.
// ----------------------------------------------------------------------------
module jps_queue #(
  parameter int WIDTH = 183
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [WIDTH-1:0]            push_data,
  input  logic                        pop,
  output logic [WIDTH-1:0]            pop_data,
  output logic                        not_empty,
  output logic [jps_pkg::Q_LVL_W-1:0] level
);

  logic [WIDTH-1:0]            entry_r [jps_pkg::Q_DEPTH];
  logic [jps_pkg::Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [jps_pkg::Q_LVL_W-1:0] level_r;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + jps_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + jps_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
        level_r <= level_r + jps_pkg::Q_LVL_W'(1);
      end else if (pop && !push) begin
        level_r <= level_r - jps_pkg::Q_LVL_W'(1);
      end
    end
  end

  assign pop_data  = entry_r[rd_ptr_r];
  assign not_empty = level_r != '0;
  assign level     = level_r;

endmodule

FILE: rtl/core/jps_back.sv
// ----------------------------------------------------------------------------
// Jacobi stencil arithmetic back end
// Scales the right-hand side, sums the neighbours, takes the quarter and
// saturates; the last stage is the result register.
// ----------------------------------------------------------------------------
module jps_back #(
  parameter int VALUE_W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_pop,
  input  logic [VALUE_W-1:0] up_value,
  input  logic [VALUE_W-1:0] down_value,
  input  logic [VALUE_W-1:0] left_value,
  input  logic [VALUE_W-1:0] right_value,
  input  logic [VALUE_W-1:0] rhs_value,
  input  jps_pkg::pt_tag_t   in_tag,
  input  logic [31:0]        h_squared,
  output logic               out_valid,
  input  logic               out_pop,
  output logic [VALUE_W-1:0] out_value,
  output jps_pkg::pt_tag_t   out_tag
);

  logic                      en;
  logic signed [VALUE_W+32:0] prod;
  logic signed [VALUE_W+1:0]  nsum;
  logic signed [VALUE_W+2:0]  total;
  logic signed [VALUE_W:0]    quarter;
  logic [VALUE_W-1:0]         sat;

  logic                       a_valid_r, b_valid_r;
  logic signed [VALUE_W+1:0]  a_nsum_r;
  logic signed [VALUE_W-1:0]  a_hf_r;
  jps_pkg::pt_tag_t           a_tag_r, b_tag_r;
  logic [VALUE_W-1:0]         b_value_r;

  // The whole pipe moves unless a finished result waits to be taken.
  assign en     = !b_valid_r || out_pop;
  assign in_pop = en && in_valid;

  assign prod = $signed(rhs_value) * $signed({1'b0, h_squared});
  assign nsum = $signed({{2{up_value[VALUE_W-1]}}, up_value})
              + $signed({{2{down_value[VALUE_W-1]}}, down_value})
              + $signed({{2{left_value[VALUE_W-1]}}, left_value})
              + $signed({{2{right_value[VALUE_W-1]}}, right_value});

  // Dropping low bits of a two's complement value rounds toward minus infinity.
  assign total   = $signed({a_nsum_r[VALUE_W+1], a_nsum_r})
                 + $signed({{3{a_hf_r[VALUE_W-1]}}, a_hf_r});
  assign quarter = total[VALUE_W+2:2];

  always_comb begin
    if (quarter[VALUE_W] != quarter[VALUE_W-1]) begin
      sat = quarter[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      sat = quarter[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_nsum_r  <= nsum;
      a_hf_r    <= prod[VALUE_W+31:32];
      a_tag_r   <= in_tag;
      b_value_r <= sat;
      b_tag_r   <= a_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  assign out_valid = b_valid_r;
  assign out_value = b_value_r;
  assign out_tag   = b_tag_r;

endmodule

FILE: dv/jacobi_poisson_stencil_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Jacobi stencil checker
// Watches the point, result and register channels of the stencil block,
// predicts every interior update from its own copy of the line buffers and
// compares each popped result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module jacobi_poisson_stencil_checker #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic                          full,
  input  logic [31:0]                   in_u_value,
  input  logic [31:0]                   in_rhs_value,
  input  logic                          in_grid_start,
  input  logic                          empty,
  input  logic                          pop,
  input  logic [31:0]                   out_new_value,
  input  logic [jps_pkg::CNT_W-1:0]     out_row,
  input  logic [jps_pkg::CNT_W-1:0]     out_col,
  input  logic                          out_last_point,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [jps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output int                            fail_count,
  output int                            pending
);

  localparam int     DEPTH  = MAX_COLS + 2;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic [31:0]               value;
    logic [jps_pkg::CNT_W-1:0] row;
    logic [jps_pkg::CNT_W-1:0] col;
    logic                      last;
  } stencil_update_t;

  logic [31:0]               u_above    [DEPTH];
  logic [31:0]               u_middle   [DEPTH];
  logic [31:0]               rhs_middle [DEPTH];
  logic [jps_pkg::CNT_W-1:0] col_count_q;
  logic [jps_pkg::CNT_W-1:0] row_count_q;
  logic [31:0]               h_squared_q;
  int unsigned               row_pos;
  int unsigned               col_pos;
  stencil_update_t           updates_due [$];
  stencil_update_t           oldest;
  int                        errors = 0;

  function automatic int unsigned clamp_count(logic [jps_pkg::CNT_W-1:0] v,
                                              int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return 32'(v);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: stencil mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // Advances the slab position by one point and queues the update it causes.
  task automatic apply_stencil_point(input logic [31:0] u, input logic [31:0] f,
                                     input logic start);
    int unsigned     cols;
    int unsigned     rows;
    int unsigned     r;
    int unsigned     c;
    longint          hf;
    longint          sum;
    longint          q;
    stencil_update_t upd;
    cols = clamp_count(col_count_q, MAX_COLS);
    rows = clamp_count(row_count_q, MAX_ROWS);
    if (start) begin
      r = 0;
      c = 0;
    end else begin
      r = row_pos;
      c = col_pos;
    end
    if (c > cols + 1) begin
      c = 0;
      r++;
    end
    if (r > rows + 1) begin
      row_pos = rows + 2;
      col_pos = 0;
      return;
    end
    if (r >= 2 && c >= 1 && c <= cols) begin
      hf  = (longint'($signed(rhs_middle[c])) * longint'(h_squared_q)) >>> 32;
      sum = longint'($signed(u_above[c])) + longint'($signed(u_above[c - 1]))
          + longint'($signed(u_middle[c + 1])) + longint'($signed(u)) + hf;
      q = sum >>> 2;
      if (q > SAT_HI) q = SAT_HI;
      if (q < SAT_LO) q = SAT_LO;
      upd.value = q[31:0];
      upd.row   = jps_pkg::CNT_W'(r - 1);
      upd.col   = jps_pkg::CNT_W'(c);
      upd.last  = (r - 1 == rows) && (c == cols);
      updates_due.push_back(upd);
    end
    u_above[c]    = u_middle[c];
    u_middle[c]   = u;
    rhs_middle[c] = f;
    c++;
    if (c > cols + 1) begin
      c = 0;
      r++;
    end
    row_pos = r;
    col_pos = c;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      col_count_q = jps_pkg::COL_COUNT_RST;
      row_count_q = jps_pkg::ROW_COUNT_RST;
      h_squared_q = jps_pkg::H_SQUARED_RST;
      row_pos     = 0;
      col_pos     = 0;
      updates_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          jps_pkg::REG_COL_COUNT: col_count_q = cfg_data[jps_pkg::CNT_W-1:0];
          jps_pkg::REG_ROW_COUNT: row_count_q = cfg_data[jps_pkg::CNT_W-1:0];
          jps_pkg::REG_H_SQUARED: h_squared_q = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) begin
        apply_stencil_point(in_u_value, in_rhs_value, in_grid_start);
      end
      if (pop && !empty) begin
        if (updates_due.size() == 0) begin
          report_mismatch("result with none due", out_new_value, '0);
        end else begin
          oldest = updates_due.pop_front();
          if (out_new_value !== oldest.value) begin
            report_mismatch("new_value", out_new_value, oldest.value);
          end
          if (out_row !== oldest.row) begin
            report_mismatch("out_row", 32'(out_row), 32'(oldest.row));
          end
          if (out_col !== oldest.col) begin
            report_mismatch("out_col", 32'(out_col), 32'(oldest.col));
          end
          if (out_last_point !== oldest.last) begin
            report_mismatch("last_point", 32'(out_last_point), 32'(oldest.last));
          end
        end
      end
    end
    pending    <= updates_due.size();
    fail_count <= errors;
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Jacobi stencil testbench
// Streams small directed slabs, then random slabs of random sizes and counts
// with broken and truncated streams mixed in, through the stencil block with
// random gaps on both queue ports; the checker beside the block judges results.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 450;
  localparam int SETTLE_CYCLES = 8;
  localparam int COUNT_MAX     = 1024;

  typedef enum {STYLE_WIDE, STYLE_NARROW, STYLE_EDGE} value_style_t;

  logic                          clk;
  logic                          rst_n         = 1'b0;
  logic                          push          = 1'b0;
  logic [31:0]                   in_u_value    = '0;
  logic [31:0]                   in_rhs_value  = '0;
  logic                          in_grid_start = 1'b0;
  logic                          pop           = 1'b0;
  logic                          cfg_valid     = 1'b0;
  logic [jps_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
  logic [31:0]                   cfg_data      = '0;
  logic                          full;
  logic                          empty;
  logic                          cfg_ready;
  logic [31:0]                   out_new_value;
  logic [jps_pkg::CNT_W-1:0]     out_row;
  logic [jps_pkg::CNT_W-1:0]     out_col;
  logic                          out_last_point;
  int                            fail_count;
  int                            pending;

  int unsigned               cycle_count = 0;
  int unsigned               pop_gap     = 0;
  int unsigned               next_gap;
  logic                      steady_in   = 1'b0;
  logic                      steady_out  = 1'b0;
  logic [jps_pkg::CNT_W-1:0] cur_cols    = jps_pkg::COL_COUNT_RST;
  logic [jps_pkg::CNT_W-1:0] cur_rows    = jps_pkg::ROW_COUNT_RST;

  jacobi_poisson_stencil dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_u_value    (in_u_value),
    .in_rhs_value  (in_rhs_value),
    .in_grid_start (in_grid_start),
    .empty         (empty),
    .pop           (pop),
    .out_new_value (out_new_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_last_point(out_last_point),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  jacobi_poisson_stencil_checker stencil_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_u_value    (in_u_value),
    .in_rhs_value  (in_rhs_value),
    .in_grid_start (in_grid_start),
    .empty         (empty),
    .pop           (pop),
    .out_new_value (out_new_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_last_point(out_last_point),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("jacobi_poisson_stencil test failed");
      $finish;
    end
  end

  function automatic int unsigned draw_gap(logic steady);
    return steady ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic int unsigned effective_count(logic [jps_pkg::CNT_W-1:0] v);
    if (v == 0) return 1;
    if (v > COUNT_MAX) return COUNT_MAX;
    return 32'(v);
  endfunction

  function automatic logic [31:0] draw_value(value_style_t style);
    case (style)
      STYLE_NARROW: return 32'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
      STYLE_EDGE: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return $urandom;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // The receiver waits a drawn number of cycles after every popped result.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop     <= 1'b0;
      pop_gap <= 0;
    end else if (pop && !empty) begin
      if ($urandom_range(0, 39) == 0) steady_out <= ~steady_out;
      next_gap = draw_gap(steady_out);
      if (next_gap != 0) begin
        pop     <= 1'b0;
        pop_gap <= next_gap;
      end
    end else if (!pop) begin
      if (pop_gap <= 1) pop <= 1'b1;
      else pop_gap <= pop_gap - 1;
    end
  end

  // Returns at the edge where the point transaction took place.
  task automatic push_point(input logic [31:0] u, input logic [31:0] f, input logic start);
    int unsigned gap;
    gap = draw_gap(steady_in);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push          <= 1'b1;
    in_u_value    <= u;
    in_rhs_value  <= f;
    in_grid_start <= start;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Holds the stream until every due result has left and the pipe is empty.
  task automatic drain_pipeline();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_one(input logic [jps_pkg::CFG_IDX_W-1:0] index,
                           input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_registers(input logic [31:0] cols_data, input logic [31:0] rows_data,
                                   input logic [31:0] h_data, input logic [2:0] which);
    if (which[0]) begin
      write_one(jps_pkg::REG_COL_COUNT, cols_data);
      cur_cols = cols_data[jps_pkg::CNT_W-1:0];
    end
    if (which[1]) begin
      write_one(jps_pkg::REG_ROW_COUNT, rows_data);
      cur_rows = rows_data[jps_pkg::CNT_W-1:0];
    end
    if (which[2]) write_one(jps_pkg::REG_H_SQUARED, h_data);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned  counted;
    int unsigned  phase;
    int unsigned  old_cols;
    int unsigned  span;
    int unsigned  length;
    int unsigned  variant;
    logic         grew;
    logic         start_fresh;
    logic         big;
    logic         start;
    logic [31:0]  cols_data;
    logic [31:0]  rows_data;
    logic [31:0]  h_data;
    logic [2:0]   which;
    value_style_t style;

    counted = 0;
    phase   = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest slab, largest spacing: the stream starts at the corner without
    // a grid_start, saturates high, then runs past the slab end.
    program_registers(32'd1, 32'd1, 32'hFFFF_FFFF, 3'b111);
    repeat (9) push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    repeat (3) push_point($urandom, $urandom, 1'b0);
    // A fresh slab of the most negative values saturates low.
    for (int i = 0; i < 9; i++) push_point(32'h8000_0000, 32'h8000_0000, i == 0);

    while (counted < RANDOM_ITEMS) begin
      phase++;
      steady_in = ($urandom_range(0, 3) == 0);
      which     = 3'b000;
      cols_data = {21'($urandom), 11'($urandom_range(0, 8))};
      rows_data = {21'($urandom), 11'($urandom_range(0, 6))};
      case ($urandom_range(0, 3))
        0: h_data = 32'h0000_0000;
        1: h_data = 32'hFFFF_FFFF;
        default: h_data = $urandom;
      endcase
      // Two phases run the counts beyond their range on one side each.
      if (phase == 3) begin
        cols_data = 32'd2047;
        rows_data = 32'd0;
        which     = 3'b111;
      end else if (phase == 7) begin
        cols_data = 32'd0;
        rows_data = 32'd2047;
        which     = 3'b111;
      end else if ($urandom_range(0, 9) < 4) begin
        which = 3'($urandom_range(1, 7));
      end

      grew = 1'b0;
      if (which != 3'b000) begin
        old_cols = effective_count(cur_cols);
        drain_pipeline();
        program_registers(cols_data, rows_data, h_data, which);
        grew = effective_count(cur_cols) > old_cols;
      end

      span = (effective_count(cur_rows) + 2) * (effective_count(cur_cols) + 2);
      big  = span > 200;
      // Wider rows would read line buffer entries never written in this slab,
      // so a wider row length always restarts the slab.
      start_fresh = grew || big || ($urandom_range(0, 4) != 0);
      variant     = $urandom_range(0, 9);
      // Large slabs are only started, which keeps the run short.
      if (big) length = $urandom_range(64, 120);
      else if (variant == 7 || variant == 8) length = $urandom_range(1, span - 1);
      else if (variant == 9) length = span + $urandom_range(1, 4);
      else length = span;
      style = value_style_t'($urandom_range(0, 2));

      for (int i = 0; i < length; i++) begin
        start = (i == 0 && start_fresh) || (!big && $urandom_range(0, 99) == 0);
        push_point(draw_value(style), draw_value(style), start);
      end
      counted += length;
    end

    drain_pipeline();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("jacobi_poisson_stencil test passed");
    end else begin
      $display("jacobi_poisson_stencil test failed");
    end
    $finish;
  end

endmodule
